@@ rtl/pcrel_pkg.sv @@
// Shared types and decode constants for the AArch64 PC-relative relocator.
package pcrel_pkg;

  localparam logic [31:0] MASK_ADR_CLASS = 32'h9F00_0000;
  localparam logic [31:0] PAT_ADR        = 32'h1000_0000;
  localparam logic [31:0] PAT_ADRP       = 32'h9000_0000;
  localparam logic [31:0] MASK_LDR_LIT   = 32'h3B00_0000;
  localparam logic [31:0] PAT_LDR_LIT    = 32'h1800_0000;
  localparam logic [31:0] MASK_B_BL      = 32'h7C00_0000;
  localparam logic [31:0] PAT_B_BL       = 32'h1400_0000;
  localparam logic [31:0] MASK_BCOND     = 32'hFF00_0010;
  localparam logic [31:0] PAT_BCOND      = 32'h5400_0000;
  localparam logic [31:0] MASK_CB_TB     = 32'h7E00_0000;
  localparam logic [31:0] PAT_CBZ        = 32'h3400_0000;
  localparam logic [31:0] PAT_TBZ        = 32'h3600_0000;

  typedef enum logic [1:0] {
    FORM_OTHER   = 2'd0,
    FORM_ADRP    = 2'd1,
    FORM_ADR     = 2'd2,
    FORM_LDR_LIT = 2'd3
  } form_kind_t;

  typedef struct packed {
    logic [31:0] instruction;
    logic [63:0] source_address;
    logic [63:0] dest_address;
  } request_t;

  typedef struct packed {
    logic [31:0] relocated_word;
    logic        out_of_range;
    logic        is_branch;
    logic        is_pc_relative;
    form_kind_t  form_kind;
  } result_t;

endpackage

@@ rtl/pcrel_if.sv @@
// Handshake channels for relocation requests and relocation results.
interface pcrel_item_if;
  logic        valid;
  logic        ready;
  logic [31:0] instruction;
  logic [63:0] source_address;
  logic [63:0] dest_address;

  modport source(output valid, output instruction, output source_address,
                 output dest_address, input ready);
  modport sink(input valid, input instruction, input source_address,
               input dest_address, output ready);
endinterface

interface pcrel_result_if;
  logic        valid;
  logic        ready;
  logic [31:0] relocated_word;
  logic        out_of_range;
  logic        is_branch;
  logic        is_pc_relative;
  logic [1:0]  form_kind;

  modport source(output valid, output relocated_word, output out_of_range,
                 output is_branch, output is_pc_relative, output form_kind,
                 input ready);
  modport sink(input valid, input relocated_word, input out_of_range,
               input is_branch, input is_pc_relative, input form_kind,
               output ready);
endinterface

@@ rtl/pcrel_rebase.sv @@
// Classify one instruction word and re-base its PC-relative immediate.
module pcrel_rebase (
  input  pcrel_pkg::request_t req,
  output pcrel_pkg::result_t  res
);

  logic [31:0]           w;
  logic [20:0]           imm21;
  logic [18:0]           imm19;
  pcrel_pkg::form_kind_t kind;
  logic [63:0]           base_a;
  logic [63:0]           base_b;
  logic [63:0]           offset;
  logic [63:0]           diff;
  logic                  fits;
  logic [31:0]           new_word;

  assign w     = req.instruction;
  assign imm21 = {w[23:5], w[30:29]};
  assign imm19 = w[23:5];

  always_comb begin
    if ((w & pcrel_pkg::MASK_ADR_CLASS) == pcrel_pkg::PAT_ADRP) begin
      kind = pcrel_pkg::FORM_ADRP;
    end else if ((w & pcrel_pkg::MASK_ADR_CLASS) == pcrel_pkg::PAT_ADR) begin
      kind = pcrel_pkg::FORM_ADR;
    end else if ((w & pcrel_pkg::MASK_LDR_LIT) == pcrel_pkg::PAT_LDR_LIT) begin
      kind = pcrel_pkg::FORM_LDR_LIT;
    end else begin
      kind = pcrel_pkg::FORM_OTHER;
    end
  end

  // One shared adder: ADRP works on page-aligned addresses, the others on bytes.
  always_comb begin
    unique case (kind)
      pcrel_pkg::FORM_ADRP: begin
        base_a = {req.source_address[63:12], 12'b0};
        base_b = {req.dest_address[63:12], 12'b0};
        offset = {{31{imm21[20]}}, imm21, 12'b0};
      end
      pcrel_pkg::FORM_LDR_LIT: begin
        base_a = req.source_address;
        base_b = req.dest_address;
        offset = {{43{imm19[18]}}, imm19, 2'b0};
      end
      pcrel_pkg::FORM_ADR, pcrel_pkg::FORM_OTHER: begin
        base_a = req.source_address;
        base_b = req.dest_address;
        offset = {{43{imm21[20]}}, imm21};
      end
    endcase
  end

  assign diff = base_a + offset - base_b;

  always_comb begin
    unique case (kind)
      pcrel_pkg::FORM_ADRP: begin
        fits     = (&diff[63:32]) | ~(|diff[63:32]);
        new_word = {w[31], diff[13:12], w[28:24], diff[32:14], w[4:0]};
      end
      pcrel_pkg::FORM_ADR: begin
        fits     = (&diff[63:20]) | ~(|diff[63:20]);
        new_word = {w[31], diff[1:0], w[28:24], diff[20:2], w[4:0]};
      end
      pcrel_pkg::FORM_LDR_LIT: begin
        fits     = ((&diff[63:20]) | ~(|diff[63:20])) & (diff[1:0] == 2'b00);
        new_word = {w[31:24], diff[20:2], w[4:0]};
      end
      pcrel_pkg::FORM_OTHER: begin
        fits     = 1'b1;
        new_word = w;
      end
    endcase
  end

  always_comb begin
    res.relocated_word = fits ? new_word : w;
    res.out_of_range   = ~fits;
    res.is_branch      = ((w & pcrel_pkg::MASK_B_BL)  == pcrel_pkg::PAT_B_BL)  ||
                         ((w & pcrel_pkg::MASK_BCOND) == pcrel_pkg::PAT_BCOND) ||
                         ((w & pcrel_pkg::MASK_CB_TB) == pcrel_pkg::PAT_CBZ)   ||
                         ((w & pcrel_pkg::MASK_CB_TB) == pcrel_pkg::PAT_TBZ);
    res.is_pc_relative = (kind != pcrel_pkg::FORM_OTHER);
    res.form_kind      = kind;
  end

endmodule

@@ rtl/aarch64_pc_relative_relocator.sv @@
// Top level of the AArch64 PC-relative instruction relocator.
//
// Each request carries one instruction word, the address it was read from and
// the address it will be copied to. ADRP, ADR and LDR-literal words get their
// immediate re-based to the new page, byte or word distance; if that distance
// does not fit (or is not word aligned for LDR-literal) out_of_range is set and
// the word passes unchanged. Immediate branches are flagged and passed
// unchanged; all other words pass unchanged. Address arithmetic wraps modulo
// 2^64. The block accepts one request every cycle unless backpressure holds it;
// each request first waits in the request register, then goes through the
// decode and the single 64-bit three-operand address adder into the result
// register. Backpressure on the result channel stalls the two stages in
// order; while a finished result waits, an empty request register can still
// take one more request and then holds it.
module aarch64_pc_relative_relocator (
  input  logic           clk,
  input  logic           rst,
  pcrel_item_if.sink     item,
  pcrel_result_if.source result
);

  // Request stage.
  logic                 req_valid;
  pcrel_pkg::request_t  req;
  // Result stage.
  logic                 res_valid;
  pcrel_pkg::result_t   res;
  pcrel_pkg::result_t   res_next;

  logic req_load;
  logic res_load;

  // Advance into the result register when it is empty or being drained.
  assign res_load   = req_valid && (!res_valid || result.ready);
  assign item.ready = !req_valid || res_load;
  assign req_load   = item.valid && item.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (req_load) begin
        req_valid <= 1'b1;
      end else if (res_load) begin
        req_valid <= 1'b0;
      end
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Hold the payload registers unless a new request or result moves in.
  always_ff @(posedge clk) begin
    if (req_load) begin
      req.instruction    <= item.instruction;
      req.source_address <= item.source_address;
      req.dest_address   <= item.dest_address;
    end
    if (res_load) begin
      res <= res_next;
    end
  end

  pcrel_rebase u_rebase (
    .req (req),
    .res (res_next)
  );

  assign result.valid          = res_valid;
  assign result.relocated_word = res.relocated_word;
  assign result.out_of_range   = res.out_of_range;
  assign result.is_branch      = res.is_branch;
  assign result.is_pc_relative = res.is_pc_relative;
  assign result.form_kind      = res.form_kind;

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for the AArch64 PC-relative relocator.
module tb;
  import pcrel_pkg::*;

  localparam logic [63:0] PAGE_MASK = ~64'hFFF;

  // Instruction encodings used by the directed requests.
  localparam logic [31:0] OP_LDR_X_LIT = 32'h5800_0000;
  localparam logic [31:0] OP_LDRSW_LIT = 32'h9800_0000;
  localparam logic [31:0] OP_PRFM_LIT  = 32'hD800_0000;
  localparam logic [31:0] OP_LDR_Q_LIT = 32'h9C00_0000;
  localparam logic [31:0] OP_BL        = 32'h9400_0000;
  localparam logic [31:0] OP_CBNZ      = 32'h3500_0000;
  localparam logic [31:0] OP_TBNZ      = 32'h3700_0000;
  localparam logic [31:0] OP_BCOND_BAD = 32'h5400_0010;
  localparam logic [31:0] OP_NOP       = 32'hD503_201F;

  logic clk;
  logic rst;

  // Idle and stall rates, in percent, for the current phase of the run.
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;

  pcrel_item_if   item ();
  pcrel_result_if result ();

  aarch64_pc_relative_relocator i_dut (
    .clk(clk),
    .rst(rst),
    .item(item),
    .result(result)
  );

  // Place a 21-bit ADR/ADRP immediate into immlo (bits 30:29) and immhi (bits 23:5).
  function automatic logic [31:0] put_adr_imm(logic [31:0] w, logic [20:0] imm);
    return {w[31], imm[1:0], w[28:24], imm[20:2], w[4:0]};
  endfunction

  function automatic logic [63:0] sext21(logic [20:0] v);
    return {{43{v[20]}}, v};
  endfunction

  // Holds the relocation expected for every accepted request, oldest first.
  class relocation_scoreboard;
    result_t     expected_results[$];
    int unsigned mismatch_count = 0;

    function result_t predict_relocation(logic [31:0] w, logic [63:0] src,
                                         logic [63:0] dst);
      result_t     r;
      logic [63:0] diff;
      r.relocated_word = w;
      r.out_of_range   = 1'b0;
      r.form_kind      = FORM_OTHER;
      r.is_branch      = ((w & MASK_B_BL) == PAT_B_BL) || ((w & MASK_BCOND) == PAT_BCOND) ||
                         ((w & MASK_CB_TB) == PAT_CBZ) || ((w & MASK_CB_TB) == PAT_TBZ);
      if ((w & MASK_ADR_CLASS) == PAT_ADRP) begin
        r.form_kind = FORM_ADRP;
        diff = (src & PAGE_MASK) + (sext21({w[23:5], w[30:29]}) << 12) - (dst & PAGE_MASK);
        if (diff + 64'h1_0000_0000 < 64'h2_0000_0000) begin
          r.relocated_word = put_adr_imm(w, diff[32:12]);
        end else begin
          r.out_of_range = 1'b1;
        end
      end else if ((w & MASK_ADR_CLASS) == PAT_ADR) begin
        r.form_kind = FORM_ADR;
        diff = src + sext21({w[23:5], w[30:29]}) - dst;
        if (diff + 64'h10_0000 < 64'h20_0000) begin
          r.relocated_word = put_adr_imm(w, diff[20:0]);
        end else begin
          r.out_of_range = 1'b1;
        end
      end else if ((w & MASK_LDR_LIT) == PAT_LDR_LIT) begin
        r.form_kind = FORM_LDR_LIT;
        diff = src + sext21({w[23:5], 2'b00}) - dst;
        if (diff[1:0] == 2'b00 && diff + 64'h10_0000 < 64'h20_0000) begin
          r.relocated_word = {w[31:24], diff[20:2], w[4:0]};
        end else begin
          r.out_of_range = 1'b1;
        end
      end
      r.is_pc_relative = (r.form_kind != FORM_OTHER);
      return r;
    endfunction

    function void note_request(logic [31:0] w, logic [63:0] src, logic [63:0] dst);
      expected_results.push_back(predict_relocation(w, src, dst));
    endfunction

    function void flag(string what, logic [63:0] want, logic [63:0] got);
      mismatch_count++;
      if (mismatch_count <= 10) begin
        $display("%0t: mismatch in %s: expected %h, got %h", $realtime, what, want, got);
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_results.size() == 0) begin
        flag("result with no request pending", 0, got.relocated_word);
        return;
      end
      want = expected_results.pop_front();
      if (got.relocated_word !== want.relocated_word)
        flag("relocated_word", want.relocated_word, got.relocated_word);
      if (got.out_of_range !== want.out_of_range)
        flag("out_of_range", want.out_of_range, got.out_of_range);
      if (got.is_branch !== want.is_branch)
        flag("is_branch", want.is_branch, got.is_branch);
      if (got.is_pc_relative !== want.is_pc_relative)
        flag("is_pc_relative", want.is_pc_relative, got.is_pc_relative);
      if (got.form_kind !== want.form_kind)
        flag("form_kind", want.form_kind, got.form_kind);
    endfunction
  endclass

  relocation_scoreboard scoreboard = new();

  // 2 ns clock.
  always begin
    #1 clk = 1'b0;
    #1 clk = 1'b1;
  end

  // Receiver: drop ready at random, at the rate of the current phase.
  always @(negedge clk) begin
    result.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Check every result that the receiver takes, against the oldest prediction.
  always @(posedge clk) begin : watch_results
    result_t got;
    if (!rst && result.valid === 1'b1 && result.ready) begin
      got.relocated_word = result.relocated_word;
      got.out_of_range   = result.out_of_range;
      got.is_branch      = result.is_branch;
      got.is_pc_relative = result.is_pc_relative;
      got.form_kind      = form_kind_t'(result.form_kind);
      scoreboard.check_result(got);
    end
  end

  // Offer one request, starting and ending at a falling edge. Idle cycles come
  // first; hold the request until it is taken at a rising edge, then note it.
  task automatic send_request(logic [31:0] w, logic [63:0] src, logic [63:0] dst);
    while ($urandom_range(99) < send_idle_pct) begin
      item.valid       <= 1'b0;
      item.instruction <= $urandom;
      @(negedge clk);
    end
    item.valid          <= 1'b1;
    item.instruction    <= w;
    item.source_address <= src;
    item.dest_address   <= dst;
    do @(posedge clk); while (!item.ready);
    scoreboard.note_request(w, src, dst);
    @(negedge clk);
  endtask

  // Hit every form at the edges of its reach, the address wrap, and each branch kind.
  task automatic run_directed();
    logic [63:0] s;
    s = {$urandom, $urandom};
    // ADR: immediate extremes land exactly on the limits; then one past each limit.
    send_request(put_adr_imm(PAT_ADR | 32'd1, 21'h0F_FFFF), s, s);
    send_request(put_adr_imm(PAT_ADR | 32'd2, 21'h10_0000), s, s);
    send_request(PAT_ADR | 32'd3, s, s - 64'h10_0000);
    send_request(PAT_ADR | 32'd4, s, s + 64'h10_0001);
    // ADR across the top of the address space.
    send_request(PAT_ADR | 32'd5, 64'd0, 64'hFFFF_FFFF_FFFF_FFFC);
    // ADRP: page limits, one page past each limit, and a page that wraps to zero.
    send_request(put_adr_imm(PAT_ADRP | 32'd6, 21'h0F_FFFF), s, s);
    send_request(put_adr_imm(PAT_ADRP | 32'd7, 21'h10_0000), s, s);
    send_request(PAT_ADRP | 32'd8, s, s - 64'h1_0000_0000);
    send_request(PAT_ADRP | 32'd9, s, s + 64'h1_0000_1000);
    send_request(put_adr_imm(PAT_ADRP | 32'd10, 21'd1), 64'hFFFF_FFFF_FFFF_FFFF, 64'd0);
    // LDR literal: word limits, one word past the top, a misaligned distance.
    send_request(OP_LDR_X_LIT | {8'd0, 19'h3_FFFF, 5'd11}, s, s);
    send_request(OP_LDR_X_LIT | {8'd0, 19'h4_0000, 5'd12}, s, s);
    send_request(OP_LDR_X_LIT | 32'd13, s, s - 64'h10_0000);
    send_request(OP_LDR_X_LIT | 32'd14, s, s + 64'd2);
    // Other literal loads count as LDR literal too.
    send_request(OP_LDRSW_LIT | {8'd0, 19'h0_0040, 5'd15}, s, s - 64'h100);
    send_request(OP_PRFM_LIT | {8'd0, 19'h7_FFF0, 5'd16}, s, s + 64'h40);
    send_request(OP_LDR_Q_LIT | 32'd17, s, s);
    // Branches pass unchanged with the flag set; a B.cond with bit 4 set is no branch.
    send_request(PAT_B_BL | 32'h03FF_FFFF, s, ~s);
    send_request(OP_BL, s, ~s);
    send_request(PAT_BCOND | 32'h0000_000E, s, ~s);
    send_request(PAT_CBZ | 32'h8000_0020, s, ~s);
    send_request(OP_CBNZ | 32'h00FF_FFE1, s, ~s);
    send_request(PAT_TBZ, s, ~s);
    send_request(OP_TBNZ | 32'h80FF_FFFF, s, ~s);
    send_request(OP_BCOND_BAD, s, ~s);
    // Plain words and the extremes of every field.
    send_request(32'h0000_0000, 64'd0, 64'd0);
    send_request(32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(OP_NOP, s, s);
  endtask

  // Mostly PC-relative words with the destination placed near, at or past the edge
  // of their reach, closer, or random; the rest are branches and arbitrary words.
  task automatic run_random(int unsigned count);
    logic [31:0] w;
    logic [63:0] s, d, reach, aim;
    logic [20:0] imm;
    int unsigned form;
    repeat (count) begin
      form = $urandom_range(9);
      s    = {$urandom, $urandom};
      w    = $urandom;
      imm  = 21'($urandom);
      reach = s;
      if (form <= 1) begin
        w     = put_adr_imm((w & ~MASK_ADR_CLASS) | PAT_ADRP, imm);
        reach = (s & PAGE_MASK) + (sext21(imm) << 12);
      end else if (form <= 3) begin
        w     = put_adr_imm((w & ~MASK_ADR_CLASS) | PAT_ADR, imm);
        reach = s + sext21(imm);
      end else if (form <= 6) begin
        w     = (w & ~MASK_LDR_LIT) | PAT_LDR_LIT;
        reach = s + sext21({w[23:5], 2'b00});
      end else if (form == 7) begin
        case ($urandom_range(3))
          0: w = (w & ~MASK_B_BL) | PAT_B_BL;
          1: w = (w & ~MASK_BCOND) | PAT_BCOND;
          2: w = (w & ~MASK_CB_TB) | PAT_CBZ;
          default: w = (w & ~MASK_CB_TB) | PAT_TBZ;
        endcase
      end
      // Distance to aim at: a limit with a few units of jitter, anywhere in
      // twice the reach, or close to zero.
      case ($urandom_range(2))
        0: aim = ($urandom_range(1) ? 64'h10_0000 : -64'h10_0000)
                 + 64'($urandom_range(12)) - 64'd6;
        1: aim = 64'($signed({$urandom, $urandom}) >>> 42);
        default: aim = 64'($signed({$urandom, $urandom}) >>> 56);
      endcase
      if (form >= 4 && form <= 6 && $urandom_range(3) != 0) aim[1:0] = 2'b00;
      if (form >= 7 || $urandom_range(4) == 0) begin
        d = {$urandom, $urandom};
      end else if (form <= 1) begin
        d = (reach - (aim << 12)) | 64'($urandom_range(4095));
      end else begin
        d = reach - aim;
      end
      send_request(w, s, d);
    end
  endtask

  initial begin
    rst                 = 1'b1;
    item.valid          = 1'b0;
    item.instruction    = '0;
    item.source_address = '0;
    item.dest_address   = '0;
    send_idle_pct       = 12;
    recv_stall_pct      = 87;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Phase one: sender rarely idles, receiver stalls most cycles.
    run_directed();
    run_random(633);
    // Phase two: the other way round.
    send_idle_pct  = 87;
    recv_stall_pct = 12;
    run_random(633);
    // Phase three: full rate on both sides.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_random(634);
    item.valid <= 1'b0;

    // Drain, then allow a few cycles for any stray result to show up.
    while (scoreboard.expected_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (scoreboard.mismatch_count == 0 && scoreboard.expected_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Hard stop in case the handshake hangs.
  initial begin
    #1_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

@@ files.f @@
rtl/pcrel_pkg.sv
rtl/pcrel_if.sv
rtl/pcrel_rebase.sv
rtl/aarch64_pc_relative_relocator.sv
dv/tb.sv
